[design/httpdf_pkg.sv]
package httpdf_pkg;

	// width of the length, remaining and chunk size counters
	localparam int COUNT_BITS = 32;

	// parser phase
	localparam logic [2:0] PH_STATUS  = 3'd0;
	localparam logic [2:0] PH_HEADERS = 3'd1;
	localparam logic [2:0] PH_BODY    = 3'd2;
	localparam logic [2:0] PH_CSIZE   = 3'd3;
	localparam logic [2:0] PH_CDATA   = 3'd4;
	localparam logic [2:0] PH_DONE    = 3'd5;
	localparam logic [2:0] PH_ERROR   = 3'd6;

	// body framing
	localparam logic [1:0] KIND_CLOSE = 2'd0;
	localparam logic [1:0] KIND_LEN   = 2'd1;
	localparam logic [1:0] KIND_CHUNK = 2'd2;

	// number scanner
	localparam logic [1:0] NP_SKIP   = 2'd0;
	localparam logic [1:0] NP_DIGITS = 2'd1;
	localparam logic [1:0] NP_STOP   = 2'd2;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam int HTTP_LEN = 7;
	localparam int CL_LEN   = 16;
	localparam int TE_LEN   = 26;

	localparam logic [HTTP_LEN*8-1:0] TAG_HTTP = "HTTP/1.";
	localparam logic [CL_LEN*8-1:0]   TAG_CL   = "Content-Length: ";
	localparam logic [TE_LEN*8-1:0]   TAG_TE   = "Transfer-Encoding: chunked";

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       conn_closed;
	} in_t;

	typedef struct packed {
		logic        body_valid;
		logic [7:0]  body_byte;
		logic        status_valid;
		logic [15:0] status_code;
		logic        done_res;
		logic        error;
	} out_t;

endpackage

[design/http_response_deframer_unit.sv]
// HTTP/1.x response deframer.
// Input channel (in_valid/in_ready/in_data): one word per response byte, or a
// word with conn_closed set when the peer closed or the receive path failed.
// Result channel (res_valid/res_ready/res_data): exactly one word per input
// word, carrying an optional decoded body byte (chunk framing removed), the
// status code once the status line is accepted, and sticky done/error flags.
// The result for a byte is registered in the result register when the byte is
// taken. Throughput: one byte per cycle while res_ready is high, set by the
// single register stage holding the parser state and the result.
// Reset puts the parser at the start of a status line with everything
// cleared and the result register empty.
// If the receiver stalls, the result waits in its register and in_ready
// drops until it is taken; a taken result frees the register in the same
// cycle a new byte is accepted, so there are no bubbles while res_ready is
// high. After done or error every further byte still gives a result word,
// with no body byte.
module http_response_deframer_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  httpdf_pkg::in_t    in_data,
	output logic               res_valid,
	input  logic               res_ready,
	output httpdf_pkg::out_t   res_data
);
	import httpdf_pkg::*;

	localparam int CB = COUNT_BITS;

	typedef struct packed {
		logic [1:0]    np;
		logic [CB-1:0] acc;
	} feed_t;

	logic [2:0]    phase_q;
	logic [1:0]    kind_q;
	logic [4:0]    pos_q;
	logic [1:0]    flags_q;
	logic [1:0]    np_q;
	logic          pcr_q;
	logic [15:0]   status_q;
	logic [CB-1:0] len_q;
	logic [CB-1:0] rem_q;
	logic [CB-1:0] csz_q;
	logic          status_ok_q;

	logic [2:0]    phase_d;
	logic [1:0]    kind_d;
	logic [4:0]    pos_d;
	logic [1:0]    flags_d;
	logic [1:0]    np_d;
	logic          pcr_d;
	logic [15:0]   status_d;
	logic [CB-1:0] len_d;
	logic [CB-1:0] rem_d;
	logic [CB-1:0] csz_d;
	logic          status_ok_d;
	logic          bv_d;
	out_t          res_d;

	logic          res_valid_q;
	out_t          res_data_q;
	logic          in_acc;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [7:0] http_ch(input logic [4:0] p);
		logic [7:0] r;
		r = 8'h00;
		if (int'(p) < HTTP_LEN)
			r = TAG_HTTP[8*(HTTP_LEN-1-int'(p)) +: 8];
		return r;
	endfunction

	function automatic logic [7:0] cl_ch(input logic [4:0] p);
		logic [7:0] r;
		r = 8'h00;
		if (int'(p) < CL_LEN)
			r = TAG_CL[8*(CL_LEN-1-int'(p)) +: 8];
		return r;
	endfunction

	function automatic logic [7:0] te_ch(input logic [4:0] p);
		logic [7:0] r;
		r = 8'h00;
		if (int'(p) < TE_LEN)
			r = TAG_TE[8*(TE_LEN-1-int'(p)) +: 8];
		return r;
	endfunction

	function automatic logic [4:0] pos_inc(input logic [4:0] p);
		return (p == 5'd31) ? p : p + 5'd1;
	endfunction

	// one digit step of a saturating decimal/hex scanner
	function automatic feed_t num_feed(input logic [1:0] np, input logic [CB-1:0] acc,
			input logic [CB-1:0] maxv, input logic hex, input logic [7:0] c);
		feed_t         r;
		logic          dv;
		logic [3:0]    d;
		logic [CB+3:0] ext;
		logic [CB+3:0] prod;
		logic [CB+3:0] sum;
		r.np = np;
		r.acc = acc;
		dv = 1'b0;
		d = 4'd0;
		if (c >= "0" && c <= "9") begin
			dv = 1'b1;
			d = c[3:0];
		end else if (hex && ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))) begin
			dv = 1'b1;
			d = c[3:0] + 4'd9;
		end
		ext = {4'b0000, acc};
		prod = hex ? (ext << 4) : ((ext << 3) + (ext << 1));
		sum = prod + {{CB{1'b0}}, d};
		if (np == NP_STOP) begin
			r.np = np;
		end else if (np == NP_SKIP && is_ws(c)) begin
			r.np = np;
		end else if (!dv) begin
			r.np = NP_STOP;
		end else begin
			r.np = NP_DIGITS;
			r.acc = (sum > {4'b0000, maxv}) ? maxv : sum[CB-1:0];
		end
		return r;
	endfunction

	always_comb begin
		logic [7:0] c;
		feed_t      f;
		c = in_data.rx_byte;
		f = '0;
		phase_d = phase_q;
		kind_d = kind_q;
		pos_d = pos_q;
		flags_d = flags_q;
		np_d = np_q;
		pcr_d = pcr_q;
		status_d = status_q;
		len_d = len_q;
		rem_d = rem_q;
		csz_d = csz_q;
		status_ok_d = status_ok_q;
		bv_d = 1'b0;

		if (phase_q == PH_DONE || phase_q >= PH_ERROR) begin
			phase_d = phase_q;
		end else if (in_data.conn_closed) begin
			phase_d = (phase_q == PH_BODY && kind_q == KIND_CLOSE) ? PH_DONE : PH_ERROR;
		end else begin
			unique case (phase_q) inside
				PH_STATUS, PH_HEADERS: begin
					if (c == CH_LF) begin
						// end of line; a held CR is dropped
						if (phase_q == PH_STATUS) begin
							if (flags_q[0] && pos_q >= 5'd7) begin
								status_ok_d = 1'b1;
								phase_d = PH_HEADERS;
							end else begin
								phase_d = PH_ERROR;
							end
						end else if (pos_q == 5'd0) begin
							if (kind_q == KIND_CHUNK) begin
								phase_d = PH_CSIZE;
								csz_d = '0;
							end else if (kind_q == KIND_LEN) begin
								rem_d = len_q;
								phase_d = (len_q == '0) ? PH_DONE : PH_BODY;
							end else begin
								phase_d = PH_BODY;
							end
						end else if (flags_q[1] && pos_q == 5'd26) begin
							kind_d = KIND_CHUNK;
						end
						pos_d = '0;
						flags_d = 2'b11;
						np_d = NP_SKIP;
						pcr_d = 1'b0;
					end else begin
						// held CR not followed by LF is an ordinary byte; it never
						// matches a tag and never feeds a digit
						if (pcr_q) begin
							if (phase_q == PH_STATUS) begin
								if (pos_d < 5'd7)
									flags_d[0] = 1'b0;
								if (pos_d >= 5'd9 && np_d == NP_DIGITS)
									np_d = NP_STOP;
							end else begin
								if (pos_d < 5'd16)
									flags_d[0] = 1'b0;
								else if (flags_d[0] && np_d == NP_DIGITS)
									np_d = NP_STOP;
								flags_d[1] = 1'b0;
							end
							pos_d = pos_inc(pos_d);
						end
						pcr_d = (c == CH_CR);
						if (c != CH_CR) begin
							if (phase_q == PH_STATUS) begin
								if (pos_d < 5'd7 && c != http_ch(pos_d))
									flags_d[0] = 1'b0;
								if (pos_d >= 5'd9) begin
									f = num_feed(np_d, {{(CB-16){1'b0}}, status_d},
										{{(CB-16){1'b0}}, 16'hFFFF}, 1'b0, c);
									np_d = f.np;
									status_d = f.acc[15:0];
								end
							end else begin
								if (pos_d < 5'd16) begin
									if (c != cl_ch(pos_d)) begin
										flags_d[0] = 1'b0;
									end else if (pos_d == 5'd15 && flags_d[0]) begin
										kind_d = KIND_LEN;
										len_d = '0;
										np_d = NP_SKIP;
									end
								end else if (flags_d[0]) begin
									f = num_feed(np_d, len_d, {CB{1'b1}}, 1'b0, c);
									np_d = f.np;
									len_d = f.acc;
								end
								if (pos_d >= 5'd26 || c != te_ch(pos_d))
									flags_d[1] = 1'b0;
							end
							pos_d = pos_inc(pos_d);
						end
					end
				end
				PH_BODY: begin
					bv_d = 1'b1;
					if (kind_q != KIND_CLOSE) begin
						if (rem_q != '0)
							rem_d = rem_q - {{(CB-1){1'b0}}, 1'b1};
						if (rem_q <= {{(CB-1){1'b0}}, 1'b1})
							phase_d = PH_DONE;
					end
				end
				PH_CSIZE: begin
					// an LF early in the line is the tail of the previous chunk
					if (c == CH_LF && pos_q >= 5'd2) begin
						if (csz_q == '0) begin
							phase_d = PH_DONE;
						end else begin
							rem_d = csz_q;
							phase_d = PH_CDATA;
						end
						pos_d = '0;
						flags_d = 2'b11;
						np_d = NP_SKIP;
						pcr_d = 1'b0;
					end else begin
						f = num_feed(np_q, csz_q, {CB{1'b1}}, 1'b1, c);
						np_d = f.np;
						csz_d = f.acc;
						pos_d = pos_inc(pos_q);
					end
				end
				PH_CDATA: begin
					bv_d = 1'b1;
					if (rem_q != '0)
						rem_d = rem_q - {{(CB-1){1'b0}}, 1'b1};
					if (rem_q <= {{(CB-1){1'b0}}, 1'b1}) begin
						phase_d = PH_CSIZE;
						csz_d = '0;
						pos_d = '0;
						flags_d = 2'b11;
						np_d = NP_SKIP;
						pcr_d = 1'b0;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end

		res_d.body_valid = bv_d;
		res_d.body_byte = bv_d ? c : 8'h00;
		res_d.status_valid = status_ok_d;
		res_d.status_code = status_ok_d ? status_d : 16'h0000;
		res_d.done_res = (phase_d == PH_DONE);
		res_d.error = (phase_d >= PH_ERROR);
	end

	assign in_ready = !res_valid_q || res_ready;
	assign in_acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STATUS;
			kind_q <= KIND_CLOSE;
			pos_q <= '0;
			flags_q <= 2'b11;
			np_q <= NP_SKIP;
			pcr_q <= 1'b0;
			status_q <= '0;
			len_q <= '0;
			rem_q <= '0;
			csz_q <= '0;
			status_ok_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				phase_q <= phase_d;
				kind_q <= kind_d;
				pos_q <= pos_d;
				flags_q <= flags_d;
				np_q <= np_d;
				pcr_q <= pcr_d;
				status_q <= status_d;
				len_q <= len_d;
				rem_q <= rem_d;
				csz_q <= csz_d;
				status_ok_q <= status_ok_d;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			res_data_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res_data = res_data_q;

`ifndef SYNTH
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |=> phase_q == PH_ERROR)
		else $error("error phase left");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("done phase left");

	a_body_after_status: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY || phase_q == PH_CSIZE || phase_q == PH_CDATA) |-> status_ok_q)
		else $error("body phase without accepted status line");

	a_res_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_data_q.done_res && res_data_q.error)
			&& !(res_data_q.body_valid && !res_data_q.status_valid))
		else $error("inconsistent result flags");
`endif

endmodule
